// ===== design/hvn_pkg.sv =====
// Shared types, constants and helper functions for the height map vertex normal block.
package hvn_pkg;

    localparam int MAX_COLS_DEF = 128;
    localparam int MAX_ROWS_DEF = 128;

    localparam int CFG_W     = 8;
    localparam int CFG_RESET = 128;
    localparam int HW        = 16;
    localparam int VW        = 18;
    localparam int SQW       = 38;
    localparam int RADW      = 54;
    localparam int ROOTW     = 27;
    localparam int REMW      = 42;
    localparam int QW        = 16;
    localparam int NW        = 16;
    localparam int IN_W      = 32;
    localparam int OUT_W     = 48;
    localparam int STEP_W    = 5;

    localparam int FETCH_STEPS = 9;
    localparam int ROOT_STEPS  = 27;
    localparam int DIV_STEPS   = 16;
    localparam int NUM_TRI     = 6;

    typedef enum logic [0:0] {
        REG_COLS = 1'b0,
        REG_ROWS = 1'b1
    } reg_idx_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_FETCH,
        S_LOAD,
        S_SQ,
        S_ROOT,
        S_DIV,
        S_ACC,
        S_DONE
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_TAKE,
        OP_CLEAR,
        OP_FETCH,
        OP_LOAD,
        OP_SQ,
        OP_ROOT,
        OP_DIV,
        OP_ACC,
        OP_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t            op;
        logic [STEP_W-1:0] step;
        logic [2:0]        tri_sel;
        logic [1:0]        comp;
    } cmd_t;

    typedef struct packed {
        logic in_query;
        logic oor;
        logic tri_ok;
    } stat_t;

    // Row offset (0: above, 1: centre, 2: below) of fetch slot s
    function automatic logic [1:0] fetch_dr(input logic [3:0] s);
        logic [1:0] r;
        begin
            case (s)
                4'd0, 4'd1, 4'd2: r = 2'd0;
                4'd3, 4'd4, 4'd5: r = 2'd1;
                default:          r = 2'd2;
            endcase
            return r;
        end
    endfunction

    // Column offset (0: west, 1: centre, 2: east) of fetch slot s
    function automatic logic [1:0] fetch_dc(input logic [3:0] s);
        logic [1:0] c;
        begin
            case (s)
                4'd0, 4'd3, 4'd6: c = 2'd0;
                4'd1, 4'd4, 4'd7: c = 2'd1;
                default:          c = 2'd2;
            endcase
            return c;
        end
    endfunction

endpackage

// ===== design/heightmap_vertex_normals.sv =====
// Top level: vertex normals over a stored height grid with wrapping columns.
// A height write is one transfer; the input stays ready, so writes can follow back to back.
// A query raises m_tvalid once its triangles, then their sum, pass the bit-serial root and divider.
// Each triangle is loaded, squared, rooted, divided and accumulated; a skipped one is only loaded.
// The first and last rows skip three triangles each; out of range goes straight to the result.
// Reset clears control and configuration (128 columns, 128 rows); the height store is not cleared.
module heightmap_vertex_normals #(
    parameter int MAX_COLS = hvn_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = hvn_pkg::MAX_ROWS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [hvn_pkg::IN_W-1:0]  s_tdata,   // row[6:0], col[13:7], height[29:14], zero pad
    input  logic                      s_tuser,   // func
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [hvn_pkg::OUT_W-1:0] m_tdata,   // normal_x[15:0], normal_y[31:16], normal_z[47:32]
    output logic                      m_tuser,   // out_of_range
    input  logic                      wr_en,
    input  logic                      wr_index,
    input  logic [hvn_pkg::CFG_W-1:0] wr_data
);

    import hvn_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    hvn_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    hvn_dp #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser) |=> !s_tready)
        else $error("query transfer did not make the block busy");

    a_write_free: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && !s_tuser) |=> s_tready)
        else $error("height write blocked the input");

    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata == '0))
        else $error("out-of-range result carries a non-zero normal");

    a_result_op: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_OUT) |=> m_tvalid)
        else $error("result load did not raise valid");

endmodule

// ===== design/hvn_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module hvn_ram #(
    parameter int W     = 16,
    parameter int DEPTH = 16384
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [W-1:0]             wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [W-1:0]             rdata
);

    logic [W-1:0] mem [DEPTH];
    logic [W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/hvn_dp.sv =====
// Datapath: height store, neighbourhood registers, square/root/divide unit and accumulator.
module hvn_dp #(
    parameter int MAX_COLS = hvn_pkg::MAX_COLS_DEF,
    parameter int MAX_ROWS = hvn_pkg::MAX_ROWS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  hvn_pkg::cmd_t               cmd,
    output hvn_pkg::stat_t              stat,
    input  logic [hvn_pkg::IN_W-1:0]    s_tdata,
    input  logic                        s_tuser,
    input  logic                        wr_en,
    input  logic                        wr_index,
    input  logic [hvn_pkg::CFG_W-1:0]   wr_data,
    output logic [hvn_pkg::OUT_W-1:0]   m_tdata,
    output logic                        m_tuser
);

    import hvn_pkg::*;

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = $clog2(DEPTH);

    logic [CFG_W-1:0] cols_reg, rows_reg;
    logic [CFG_W-1:0] cols_eff, rows_eff;

    logic [6:0] in_row, in_col;
    logic [HW-1:0] in_h;
    logic [6:0] row_reg, col_reg;
    logic       oor_reg;

    logic [CFG_W-1:0] cw, c1, rsel, csel;
    logic [1:0]       fr, fc;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [HW-1:0] rdata;

    logic [HW-1:0]        h_reg [9];
    logic signed [VW-1:0] v_reg [3];
    logic signed [VW-1:0] acc_reg [3];
    logic signed [NW-1:0] unit_reg [3];
    logic signed [VW-1:0] tx, ty, tz, vsel;
    logic signed [2*VW-1:0] prod;

    logic [SQW-1:0]   sum_reg;
    logic [RADW-1:0]  rad_reg, res_reg, bit_reg, trial;
    logic [ROOTW-1:0] root;
    logic [REMW-1:0]  rem_reg, dsh_reg;
    logic [QW-1:0]    q_reg, q_next;
    logic [VW-1:0]    mag;
    logic             ge;

    logic [OUT_W-1:0] m_tdata_reg;
    logic             m_tuser_reg;

    function automatic logic signed [VW-1:0] df(input logic [HW-1:0] a, input logic [HW-1:0] b);
        logic signed [VW-1:0] ea, eb;
        begin
            ea = {{(VW-HW){a[HW-1]}}, a};
            eb = {{(VW-HW){b[HW-1]}}, b};
            return ea - eb;
        end
    endfunction

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg <= CFG_W'(CFG_RESET);
            rows_reg <= CFG_W'(CFG_RESET);
        end
        else if (wr_en)
        begin
            unique case (reg_idx_t'(wr_index))
                REG_COLS: cols_reg <= wr_data;
                REG_ROWS: rows_reg <= wr_data;
                default:  ;
            endcase
        end
    end

    always_comb
    begin
        if (cols_reg < CFG_W'(2))
            cols_eff = CFG_W'(2);
        else if (32'(cols_reg) > MAX_COLS)
            cols_eff = CFG_W'(MAX_COLS);
        else
            cols_eff = cols_reg;
        if (rows_reg < CFG_W'(2))
            rows_eff = CFG_W'(2);
        else if (32'(rows_reg) > MAX_ROWS)
            rows_eff = CFG_W'(MAX_ROWS);
        else
            rows_eff = rows_reg;
    end

    assign in_row = s_tdata[6:0];
    assign in_col = s_tdata[13:7];
    assign in_h   = s_tdata[29:14];

    assign stat.in_query = s_tuser;
    assign stat.oor      = oor_reg;
    assign stat.tri_ok   = (cmd.tri_sel < 3'd3) ? (row_reg != 7'd0)
                                                : (({1'b0, row_reg} + CFG_W'(1)) < rows_eff);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oor_reg <= 1'b0;
        end
        else if (cmd.op == OP_TAKE)
        begin
            oor_reg <= ({1'b0, in_row} >= rows_eff) || ({1'b0, in_col} >= cols_eff);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_TAKE)
        begin
            row_reg <= in_row;
            col_reg <= in_col;
        end
    end

    // height store
    assign we    = (cmd.op == OP_TAKE) && !s_tuser
                   && (32'(in_row) < MAX_ROWS) && (32'(in_col) < MAX_COLS);
    assign waddr = AW'(32'(in_row) * MAX_COLS + 32'(in_col));

    assign cw = (col_reg == 7'd0) ? cols_eff - CFG_W'(1) : {1'b0, col_reg} - CFG_W'(1);
    assign c1 = (({1'b0, col_reg} + CFG_W'(1)) == cols_eff) ? '0
                                                           : {1'b0, col_reg} + CFG_W'(1);
    assign fr = fetch_dr(cmd.step[3:0]);
    assign fc = fetch_dc(cmd.step[3:0]);

    always_comb
    begin
        case (fr)
            2'd0:    rsel = (row_reg == 7'd0) ? '0 : {1'b0, row_reg} - CFG_W'(1);
            2'd1:    rsel = {1'b0, row_reg};
            default: rsel = ((32'(row_reg) + 1) < MAX_ROWS) ? {1'b0, row_reg} + CFG_W'(1)
                                                            : {1'b0, row_reg};
        endcase
        case (fc)
            2'd0:    csel = cw;
            2'd1:    csel = {1'b0, col_reg};
            default: csel = c1;
        endcase
    end

    assign raddr = AW'(32'(rsel) * MAX_COLS + 32'(csel));

    hvn_ram #(
        .W     (HW),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (in_h),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_FETCH && cmd.step != '0)
        begin
            h_reg[4'(cmd.step - STEP_W'(1))] <= rdata;
        end
    end

    // triangle edge vectors over the 3x3 neighbourhood, or the accumulated sum
    always_comb
    begin
        ty = VW'(256);
        case (cmd.tri_sel)
            3'd0:
            begin
                tx = df(h_reg[3], h_reg[4]);
                tz = df(h_reg[1], h_reg[4]);
            end
            3'd1:
            begin
                tx = -df(h_reg[2], h_reg[1]);
                tz = -df(h_reg[4], h_reg[1]);
            end
            3'd2:
            begin
                tx = df(h_reg[4], h_reg[5]);
                tz = df(h_reg[2], h_reg[5]);
            end
            3'd3:
            begin
                tx = -df(h_reg[5], h_reg[4]);
                tz = -df(h_reg[7], h_reg[4]);
            end
            3'd4:
            begin
                tx = -df(h_reg[4], h_reg[3]);
                tz = -df(h_reg[6], h_reg[3]);
            end
            3'd5:
            begin
                tx = df(h_reg[6], h_reg[7]);
                tz = df(h_reg[4], h_reg[7]);
            end
            default:
            begin
                tx = acc_reg[0];
                ty = acc_reg[1];
                tz = -acc_reg[2];
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_LOAD)
        begin
            v_reg[0] <= tx;
            v_reg[1] <= ty;
            v_reg[2] <= tz;
        end
    end

    assign vsel = v_reg[cmd.comp];
    assign prod = vsel * vsel;

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_SQ)
        begin
            sum_reg <= ((cmd.comp == 2'd0) ? '0 : sum_reg) + SQW'($unsigned(prod));
        end
    end

    // integer square root, one result bit per step
    assign trial = res_reg + bit_reg;
    assign root  = res_reg[ROOTW-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_ROOT)
        begin
            if (cmd.step == '0)
            begin
                rad_reg <= {sum_reg, 16'b0};
                res_reg <= '0;
                bit_reg <= RADW'(1) << (RADW - 2);
            end
            else
            begin
                if (rad_reg >= trial)
                begin
                    rad_reg <= rad_reg - trial;
                    res_reg <= (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_reg <= res_reg >> 1;
                end
                bit_reg <= bit_reg >> 2;
            end
        end
    end

    // rounded restoring divide, one quotient bit per step
    assign mag    = vsel[VW-1] ? VW'(-vsel) : VW'(vsel);
    assign ge     = rem_reg >= dsh_reg;
    assign q_next = {q_reg[QW-2:0], ge};

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_DIV)
        begin
            if (cmd.step == '0)
            begin
                rem_reg <= REMW'({mag, 22'b0}) + REMW'(root >> 1);
                dsh_reg <= REMW'({root, 15'b0});
                q_reg   <= '0;
            end
            else
            begin
                if (ge)
                begin
                    rem_reg <= rem_reg - dsh_reg;
                end
                dsh_reg <= dsh_reg >> 1;
                q_reg   <= q_next;
                if (cmd.step == STEP_W'(DIV_STEPS))
                begin
                    unit_reg[cmd.comp] <= vsel[VW-1] ? -$signed(q_next) : $signed(q_next);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_CLEAR)
        begin
            acc_reg[0] <= '0;
            acc_reg[1] <= '0;
            acc_reg[2] <= '0;
        end
        else if (cmd.op == OP_ACC)
        begin
            acc_reg[0] <= acc_reg[0] + VW'(unit_reg[0]);
            acc_reg[1] <= acc_reg[1] + VW'(unit_reg[1]);
            acc_reg[2] <= acc_reg[2] + VW'(unit_reg[2]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_OUT)
        begin
            m_tdata_reg <= oor_reg ? '0 : {unit_reg[2], unit_reg[1], unit_reg[0]};
            m_tuser_reg <= oor_reg;
        end
    end

    assign m_tdata = m_tdata_reg;
    assign m_tuser = m_tuser_reg;

endmodule

// ===== design/hvn_ctrl.sv =====
// Controller: sequences fetch, per-triangle normalisation, accumulation and result transfer.
module hvn_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    output logic           m_tvalid,
    input  logic           m_tready,
    input  hvn_pkg::stat_t stat,
    output hvn_pkg::cmd_t  cmd
);

    import hvn_pkg::*;

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [2:0]        tri_reg, tri_next;
    logic [1:0]        comp_reg, comp_next;
    logic              mvalid_reg, mvalid_next;
    logic              out_free;
    dp_op_t            op;

    assign out_free = !mvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            step_reg   <= '0;
            tri_reg    <= '0;
            comp_reg   <= '0;
            mvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            step_reg   <= step_next;
            tri_reg    <= tri_next;
            comp_reg   <= comp_next;
            mvalid_reg <= mvalid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        tri_next   = tri_reg;
        comp_next  = comp_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid && stat.in_query)
                    state_next = S_CHECK;
            end
            S_CHECK:
            begin
                step_next  = '0;
                tri_next   = '0;
                comp_next  = '0;
                state_next = stat.oor ? S_DONE : S_FETCH;
            end
            S_FETCH:
            begin
                if (step_reg == STEP_W'(FETCH_STEPS))
                begin
                    step_next  = '0;
                    state_next = S_LOAD;
                end
                else
                    step_next = step_reg + STEP_W'(1);
            end
            S_LOAD:
            begin
                if (tri_reg == 3'(NUM_TRI) || stat.tri_ok)
                begin
                    comp_next  = '0;
                    state_next = S_SQ;
                end
                else
                    tri_next = tri_reg + 3'd1;
            end
            S_SQ:
            begin
                if (comp_reg == 2'd2)
                begin
                    comp_next  = '0;
                    step_next  = '0;
                    state_next = S_ROOT;
                end
                else
                    comp_next = comp_reg + 2'd1;
            end
            S_ROOT:
            begin
                if (step_reg == STEP_W'(ROOT_STEPS))
                begin
                    step_next  = '0;
                    state_next = S_DIV;
                end
                else
                    step_next = step_reg + STEP_W'(1);
            end
            S_DIV:
            begin
                if (step_reg == STEP_W'(DIV_STEPS))
                begin
                    step_next = '0;
                    if (comp_reg == 2'd2)
                    begin
                        comp_next  = '0;
                        state_next = (tri_reg == 3'(NUM_TRI)) ? S_DONE : S_ACC;
                    end
                    else
                        comp_next = comp_reg + 2'd1;
                end
                else
                    step_next = step_reg + STEP_W'(1);
            end
            S_ACC:
            begin
                tri_next   = tri_reg + 3'd1;
                state_next = S_LOAD;
            end
            S_DONE:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        s_tready    = 1'b0;
        op          = OP_NONE;
        mvalid_next = mvalid_reg && !m_tready;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                    op = OP_TAKE;
            end
            S_CHECK: op = OP_CLEAR;
            S_FETCH: op = OP_FETCH;
            S_LOAD:  op = OP_LOAD;
            S_SQ:    op = OP_SQ;
            S_ROOT:  op = OP_ROOT;
            S_DIV:   op = OP_DIV;
            S_ACC:   op = OP_ACC;
            S_DONE:
            begin
                if (out_free)
                begin
                    op          = OP_OUT;
                    mvalid_next = 1'b1;
                end
            end
            default: op = OP_NONE;
        endcase
    end

    assign m_tvalid    = mvalid_reg;
    assign cmd.op      = op;
    assign cmd.step    = step_reg;
    assign cmd.tri_sel = tri_reg;
    assign cmd.comp    = comp_reg;

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for heightmap_vertex_normals: random and directed height writes and
// vertex normal queries, checked against a bit-exact predictor.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import hvn_pkg::*;

    localparam int NCOL = 128;
    localparam int NROW = 128;
    localparam longint LIMIT = 5000000;

    typedef struct {
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic signed [15:0] nz;
        logic               oor;
    } normal_t;

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [IN_W-1:0]     s_tdata;
    logic                s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [OUT_W-1:0]    m_tdata;
    logic                m_tuser;
    logic                wr_en;
    logic                wr_index;
    logic [CFG_W-1:0]    wr_data;

    logic signed [15:0]  heights [NROW][NCOL];
    bit                  written [NROW][NCOL];
    logic [7:0]          grid_cols;
    logic [7:0]          grid_rows;
    normal_t             normals_due[$];
    int                  errors;
    int                  sent;
    longint              cycle;
    longint              hold_until;
    int                  tx_idle_pct;
    int                  rx_idle_pct;

    heightmap_vertex_normals uut (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle <= cycle + 1;
        if (cycle > LIMIT)
        begin
            $display("tb failed");
            $finish;
        end
    end

    always @(posedge clk)
        m_tready <= (cycle >= hold_until) && ($urandom_range(99) >= rx_idle_pct);

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0)
        begin
            if (n >= res + bitv)
            begin
                n -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic longint round_div(longint n, longint d);
        longint m;
        longint q;
        m = (n < 0) ? -n : n;
        q = (m + d / 2) / d;
        return (n < 0) ? -q : q;
    endfunction

    function automatic void unit_vec(inout longint v[3]);
        longint unsigned len;
        len = int_sqrt((v[0] * v[0] + v[1] * v[1] + v[2] * v[2]) << 16);
        for (int k = 0; k < 3; k++)
            v[k] = (len == 0) ? 0 : round_div(v[k] * 4194304, len);
    endfunction

    function automatic longint hgt(int r, int c);
        return longint'(heights[r][c]);
    endfunction

    function automatic void add_tri(inout longint acc[3], input bit down, int r, int c, int cols);
        longint v[3];
        int c1;
        c1 = (c + 1) % cols;
        if (down)
        begin
            v[0] = hgt(r + 1, c) - hgt(r + 1, c1);
            v[2] = hgt(r, c1) - hgt(r + 1, c1);
        end
        else
        begin
            v[0] = hgt(r, c) - hgt(r, c1);
            v[2] = hgt(r, c) - hgt(r + 1, c);
        end
        v[1] = 256;
        unit_vec(v);
        for (int k = 0; k < 3; k++) acc[k] += v[k];
    endfunction

    function automatic int sat_size(int v);
        return (v < 2) ? 2 : (v > 128) ? 128 : v;
    endfunction

    function automatic normal_t vertex_normal(int r, int c);
        normal_t n;
        longint acc[3];
        int cols;
        int rows;
        int cw;
        cols = sat_size(grid_cols);
        rows = sat_size(grid_rows);
        n = '{0, 0, 0, 1'b1};
        if (r >= rows || c >= cols) return n;
        acc = '{0, 0, 0};
        cw = (c == 0) ? cols - 1 : c - 1;
        if (r > 0)
        begin
            add_tri(acc, 1'b1, r - 1, cw, cols);
            add_tri(acc, 1'b0, r - 1, c, cols);
            add_tri(acc, 1'b1, r - 1, c, cols);
        end
        if (r + 1 < rows)
        begin
            add_tri(acc, 1'b0, r, c, cols);
            add_tri(acc, 1'b0, r, cw, cols);
            add_tri(acc, 1'b1, r, cw, cols);
        end
        acc[2] = -acc[2];
        unit_vec(acc);
        n.nx = acc[0][15:0];
        n.ny = acc[1][15:0];
        n.nz = acc[2][15:0];
        n.oor = 1'b0;
        return n;
    endfunction

    task automatic report(string what, longint got, longint want);
        $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle, what, got, want);
        errors++;
    endtask

    always @(posedge clk)
    begin
        normal_t got;
        normal_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.nx = m_tdata[15:0];
            got.ny = m_tdata[31:16];
            got.nz = m_tdata[47:32];
            got.oor = m_tuser;
            if (normals_due.size() == 0)
                report("unexpected result, normal_x", got.nx, 0);
            else
            begin
                want = normals_due.pop_front();
                if (got.nx !== want.nx) report("normal_x", got.nx, want.nx);
                if (got.ny !== want.ny) report("normal_y", got.ny, want.ny);
                if (got.nz !== want.nz) report("normal_z", got.nz, want.nz);
                if (got.oor !== want.oor) report("out_of_range", got.oor, want.oor);
            end
        end
    end

    task automatic send(bit query, int r, int c, logic signed [15:0] h);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= query;
        s_tdata  <= {2'b00, h, 7'(c), 7'(r)};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sent++;
        if (query)
            normals_due = {normals_due, vertex_normal(r, c)};
        else
        begin
            heights[r][c] = h;
            written[r][c] = 1'b1;
        end
    endtask

    function automatic logic signed [15:0] rand_height();
        case ($urandom_range(3))
            0:       return 16'($urandom);
            1:       return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
            default: return 16'($signed(11'($urandom)));
        endcase
    endfunction

    // write any height of an in-range vertex's neighbourhood not yet stored, then query
    task automatic query(int r, int c);
        int cols;
        int rows;
        int cw;
        int c1;
        cols = sat_size(grid_cols);
        rows = sat_size(grid_rows);
        if (r < rows && c < cols)
        begin
            cw = (c == 0) ? cols - 1 : c - 1;
            c1 = (c + 1) % cols;
            for (int dr = -1; dr <= 1; dr++)
            begin
                if (r + dr >= 0 && r + dr < rows)
                begin
                    if (!written[r + dr][cw]) send(1'b0, r + dr, cw, rand_height());
                    if (!written[r + dr][c])  send(1'b0, r + dr, c, rand_height());
                    if (!written[r + dr][c1]) send(1'b0, r + dr, c1, rand_height());
                end
            end
        end
        send(1'b1, r, c, 16'($urandom));
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (normals_due.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic set_grid(int cols, int rows);
        drain();
        wr_en    <= 1'b1;
        wr_index <= REG_COLS;
        wr_data  <= 8'(cols);
        @(posedge clk);
        wr_index <= REG_ROWS;
        wr_data  <= 8'(rows);
        @(posedge clk);
        wr_en    <= 1'b0;
        grid_cols = 8'(cols);
        grid_rows = 8'(rows);
        @(posedge clk);
    endtask

    task automatic test_corners();
        int cs[4] = '{2, 128, 2, 128};
        int rs[4] = '{2, 128, 128, 2};
        int cl;
        int rl;
        for (int i = 0; i < 4; i++)
        begin
            set_grid(cs[i], rs[i]);
            cl = cs[i] - 1;
            rl = rs[i] - 1;
            query(0, 0);
            query(0, cl);
            query(rl, 0);
            query(rl, cl);
            query(rs[i] / 2, cs[i] / 2);
            query(127, 127);
        end
        set_grid(128, 128);
        send(1'b0, 5, 5, 16'sh7fff);
        send(1'b0, 6, 5, 16'sh8000);
        send(1'b0, 5, 6, 16'sh8000);
        query(5, 5);
        query(6, 6);
    endtask

    task automatic test_saturation();
        set_grid(0, 1);
        query(1, 1);
        query(2, 0);
        set_grid(255, 200);
        query(127, 127);
        query(64, 0);
    endtask

    task automatic random_items(int count);
        int cols;
        int rows;
        int stop;
        stop = sent + count;
        while (sent < stop)
        begin
            cols = sat_size(grid_cols);
            rows = sat_size(grid_rows);
            if ($urandom_range(99) < 45)
                send(1'b0, $urandom_range(127), $urandom_range(127), rand_height());
            else if ($urandom_range(9) == 0)
                query($urandom_range(127), $urandom_range(127));
            else
                query($urandom_range(rows - 1), $urandom_range(cols - 1));
        end
    endtask

    task automatic test_random(int tx_pct, int rx_pct);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        for (int k = 0; k < 5; k++)
        begin
            case (k)
                0:       set_grid(128, 128);
                1:       set_grid(2, $urandom_range(2, 128));
                2:       set_grid($urandom_range(2, 128), 2);
                default: set_grid($urandom_range(255), $urandom_range(255));
            endcase
            random_items(90);
        end
    endtask

    task automatic test_backpressure();
        set_grid(16, 16);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_until = cycle + 4000;
        random_items(40);
    endtask

    initial
    begin
        rst_n       <= 1'b0;
        s_tvalid    <= 1'b0;
        s_tuser     <= 1'b0;
        s_tdata     <= '0;
        m_tready    <= 1'b0;
        wr_en       <= 1'b0;
        wr_index    <= REG_COLS;
        wr_data     <= '0;
        cycle       <= 0;
        hold_until  = 0;
        errors      = 0;
        sent        = 0;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        grid_cols   = 8'd128;
        grid_rows   = 8'd128;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_corners();
        test_saturation();
        test_random(38, 78);
        test_random(78, 38);
        test_random(0, 0);
        test_backpressure();
        drain();
        if (errors == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end
endmodule
